### src/nfcrd_pkg.sv
// shared types and codes for the controller response deframer
// no dependencies
`default_nettype none

package nfcrd_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] DirFromController = 8'hD5;
  localparam logic [7:0] StartSecond       = 8'hFF;
  localparam logic [7:0] HuntFill          = 8'hAA;
  localparam logic [7:0] PostambleByte     = 8'h00;

  // input item kinds
  localparam logic FUNC_ARM  = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_BAD_HEADER    = 2'd1,
    STATUS_BAD_CHECKSUM  = 2'd2,
    STATUS_BAD_POSTAMBLE = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HUNT   = 3'd1,
    PH_LEN    = 3'd2,
    PH_LENCHK = 3'd3,
    PH_DIR    = 3'd4,
    PH_CODE   = 3'd5,
    PH_DATA   = 3'd6,
    PH_POST   = 3'd7
  } phase_t;

  // one classified word in the queue between front and back
  typedef struct packed {
    logic       arm;
    logic [7:0] data;
  } qentry_t;

  // queue handshake driven by the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

endpackage

`default_nettype wire

### src/nfc_controller_response_deframer.sv
// top level of the controller response deframer
// depends on nfcrd_pkg, nfcrd_front, nfcrd_queue, nfcrd_back
`default_nettype none

// Parses response frames from a contactless controller host link, one word
// per cycle. An arm word (func = 0) loads the expected command and starts a
// hunt for the 00 FF start code; byte words (func = 1) then walk the header
// (length, length checksum, direction D5, response code = command + 1), the
// payload, the data checksum and the postamble. Each payload byte comes out
// as a payload result with its index, and one status result closes the
// frame (ok, bad header, bad checksum, bad postamble). Bytes seen while idle
// are dropped, and a new arm abandons any frame in flight. Throughput is one
// word per cycle while the output register is not stalled. The front end
// writes accepted words into a four-entry queue, so in_ready only drops
// when that queue is full; the parser drains it whenever the output
// register is empty or being taken. An accepted word is registered in the
// queue, and the parser then pops it and registers its result in the
// output register.

module nfc_controller_response_deframer
  import nfcrd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       func,
  input  wire logic [7:0] expected_command,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            result_kind,
  output logic [7:0]      payload_byte,
  output logic [7:0]      payload_index,
  output logic [1:0]      frame_status,
  output logic [7:0]      payload_length
);

  // front to queue
  logic    q_push;
  logic    q_full;
  qentry_t q_wr_entry;

  // queue to back
  qentry_t q_rd_entry;
  qctl_t   q_ctl;
  logic    q_valid;

  nfcrd_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .expected_command (expected_command),
    .rx_byte          (rx_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_wr_entry)
  );

  nfcrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .ctl      (q_ctl),
    .rd_entry (q_rd_entry),
    .not_empty(q_valid)
  );

  // parser plus output register
  nfcrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_entry        (q_rd_entry),
    .q_valid        (q_valid),
    .q_ctl          (q_ctl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .frame_status   (frame_status),
    .payload_length (payload_length)
  );

endmodule

`default_nettype wire

### src/nfcrd_front.sv
// front end: accepts input words and classifies them into queue entries
// depends on nfcrd_pkg
`default_nettype none

module nfcrd_front
  import nfcrd_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       func,
  input  wire logic [7:0] expected_command,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output qentry_t         q_entry
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // arm words carry the command, byte words carry the received byte
  always_comb begin
    q_entry.arm  = (func == FUNC_ARM);
    q_entry.data = (func == FUNC_ARM) ? expected_command : rx_byte;
  end

endmodule

`default_nettype wire

### src/nfcrd_queue.sv
// small fifo decoupling the front end from the frame parser
// depends on nfcrd_pkg
`default_nettype none

module nfcrd_queue
  import nfcrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire qentry_t wr_entry,
  output logic         full,
  input  wire qctl_t   ctl,
  output qentry_t      rd_entry,
  output logic         not_empty
);

  qentry_t               mem [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr;
  logic [QueuePtrW-1:0]  rd_ptr;
  logic [QueueCntW-1:0]  count;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QueuePtrW'(1);
      if (ctl.pop) rd_ptr <= rd_ptr + QueuePtrW'(1);
      case ({push, ctl.pop})
        2'b10:   count <= count + QueueCntW'(1);
        2'b01:   count <= count - QueueCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/nfcrd_back.sv
// back end: frame parser state machine and output register
// depends on nfcrd_pkg
`default_nettype none

module nfcrd_back
  import nfcrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire qentry_t q_entry,
  input  wire logic    q_valid,
  output qctl_t        q_ctl,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic         result_kind,
  output logic [7:0]   payload_byte,
  output logic [7:0]   payload_index,
  output logic [1:0]   frame_status,
  output logic [7:0]   payload_length
);

  phase_t     phase, phase_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] length_check, length_check_next;
  logic       header_fault, header_fault_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] expected_code, expected_code_next;
  logic       checksum_fault, checksum_fault_next;

  logic          fire;
  logic          emit;
  logic          emit_kind;
  logic [7:0]    emit_byte;
  logic [7:0]    emit_index;
  frame_status_t emit_status;
  logic [7:0]    emit_length;
  logic [7:0]    plen;
  logic [7:0]    b;
  logic          bad;

  assign fire        = q_valid && (!out_valid || out_ready);
  assign q_ctl.valid = q_valid;
  assign q_ctl.pop   = fire;
  assign b           = q_entry.data;
  assign plen        = frame_length - 8'd2;

  always_comb begin
    phase_next          = phase;
    previous_byte_next  = previous_byte;
    frame_length_next   = frame_length;
    length_check_next   = length_check;
    header_fault_next   = header_fault;
    running_sum_next    = running_sum;
    payload_count_next  = payload_count;
    expected_code_next  = expected_code;
    checksum_fault_next = checksum_fault;
    emit        = 1'b0;
    emit_kind   = KIND_STATUS;
    emit_byte   = '0;
    emit_index  = '0;
    emit_status = STATUS_OK;
    emit_length = '0;
    bad         = header_fault
                  || ((frame_length + length_check) != 8'd0)
                  || (({1'b0, expected_code} + 9'd1) != {1'b0, b})
                  || (frame_length < 8'd2);

    if (fire) begin
      if (q_entry.arm) begin
        phase_next          = PH_HUNT;
        previous_byte_next  = HuntFill;
        frame_length_next   = '0;
        length_check_next   = '0;
        header_fault_next   = 1'b0;
        running_sum_next    = '0;
        payload_count_next  = '0;
        expected_code_next  = b;
        checksum_fault_next = 1'b0;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (previous_byte == 8'h00 && b == StartSecond) phase_next = PH_LEN;
            previous_byte_next = b;
          end
          PH_LEN: begin
            frame_length_next = b;
            phase_next        = PH_LENCHK;
          end
          PH_LENCHK: begin
            length_check_next = b;
            phase_next        = PH_DIR;
          end
          PH_DIR: begin
            header_fault_next = (b != DirFromController);
            running_sum_next  = b;
            phase_next        = PH_CODE;
          end
          PH_CODE: begin
            running_sum_next  = running_sum + b;
            header_fault_next = bad;
            if (bad) begin
              phase_next  = PH_IDLE;
              emit        = 1'b1;
              emit_status = STATUS_BAD_HEADER;
            end else begin
              payload_count_next = '0;
              phase_next         = PH_DATA;
            end
          end
          PH_DATA: begin
            if (payload_count < plen) begin
              running_sum_next   = running_sum + b;
              payload_count_next = payload_count + 8'd1;
              emit       = 1'b1;
              emit_kind  = KIND_PAYLOAD;
              emit_byte  = b;
              emit_index = payload_count;
            end else begin
              checksum_fault_next = ((running_sum + b) != 8'd0);
              phase_next          = PH_POST;
            end
          end
          PH_POST: begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            emit_length = plen;
            if (checksum_fault) emit_status = STATUS_BAD_CHECKSUM;
            else if (b != PostambleByte) emit_status = STATUS_BAD_POSTAMBLE;
            else emit_status = STATUS_OK;
          end
          default: begin
            // idle: stray bytes are dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      previous_byte  <= HuntFill;
      frame_length   <= '0;
      length_check   <= '0;
      header_fault   <= 1'b0;
      running_sum    <= '0;
      payload_count  <= '0;
      expected_code  <= '0;
      checksum_fault <= 1'b0;
    end else begin
      phase          <= phase_next;
      previous_byte  <= previous_byte_next;
      frame_length   <= frame_length_next;
      length_check   <= length_check_next;
      header_fault   <= header_fault_next;
      running_sum    <= running_sum_next;
      payload_count  <= payload_count_next;
      expected_code  <= expected_code_next;
      checksum_fault <= checksum_fault_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result_kind    <= emit_kind;
      payload_byte   <= emit_byte;
      payload_index  <= emit_index;
      frame_status   <= emit_status;
      payload_length <= emit_length;
    end
  end

endmodule

`default_nettype wire

### src/nfcrd_checker.sv
// port-level checks for the controller response deframer, bound to the top
// depends on nfcrd_pkg and nfc_controller_response_deframer
`default_nettype none

module nfcrd_checker
  import nfcrd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       result_kind,
  input wire logic [7:0] payload_byte,
  input wire logic [7:0] payload_index,
  input wire logic [1:0] frame_status,
  input wire logic [7:0] payload_length
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind)
      && $stable(payload_byte) && $stable(payload_index)
      && $stable(frame_status) && $stable(payload_length))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |->
      frame_status == STATUS_OK && payload_length == 8'd0)
    else $error("payload word carries status fields");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |->
      payload_byte == 8'd0 && payload_index == 8'd0
      && (frame_status != STATUS_BAD_HEADER || payload_length == 8'd0))
    else $error("status word carries payload fields");

endmodule

bind nfc_controller_response_deframer nfcrd_checker u_nfcrd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .result_kind    (result_kind),
  .payload_byte   (payload_byte),
  .payload_index  (payload_index),
  .frame_status   (frame_status),
  .payload_length (payload_length)
);

`default_nettype wire
